[design/assert_macros.svh]
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define SWB_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent implies consequent on the same edge.
`define SWB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define SWB_ASSERT(name, cond, msg)
`define SWB_ASSERT_IMP(name, ante, cons, msg)

`endif

`endif

[design/swbft_pkg.sv]
package swbft_pkg;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register select: paddr[2] picks the register (byte addresses 0 and 4)
  localparam logic REG_FRAME_TICKS = 1'b0;
  localparam logic REG_FIRST_BIT   = 1'b1;

  localparam logic [7:0] FRAME_TICKS_RST = 8'd100;
  localparam logic [7:0] FIRST_BIT_RST   = 8'd4;

  // Tick kind carried in tuser
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Result beat, lowest bit is drive_enable
  typedef struct packed {
    logic       transmitted;
    logic       received_any;
    logic [7:0] received_byte;
    logic       done_res;
    logic       busy_res;
    logic       drive_level;
    logic       drive_enable;
  } swbft_res_t;

endpackage

[design/single_wire_bus_frame_transceiver_core.sv]
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser: mode; tdata: send_byte, backoff, line_level
// m_axis    out  tvalid/tready          tdata: drive/status flags and received_byte
// apb       in   psel/penable/pready    frame_ticks @0x0, first_bit_tick @0x4
//
// One beat per clock cycle while the skid is empty; each result is registered.
// The whole tick update is a single pass from the state registers into the
// result register; a skid register keeps s_axis_tready high while one
// result waits. Reset (async, active low) returns to idle with default registers.
// No clearing pass after reset.
module single_wire_bus_frame_transceiver_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swbft_pkg::InDataW-1:0]   s_axis_tdata,  // send_byte[7:0], backoff[15:8],
                                                         // line_level[16], zero fill
  input  logic                            s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [swbft_pkg::OutDataW-1:0]  m_axis_tdata,  // drive_enable, drive_level,
                                                         // busy_res, done_res,
                                                         // received_byte[11:4],
                                                         // received_any, transmitted
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swbft_pkg::ApbAddrW-1:0]  paddr,
  input  logic [swbft_pkg::ApbDataW-1:0]  pwdata,
  output logic [swbft_pkg::ApbDataW-1:0]  prdata,
  output logic                            pready
);
  import swbft_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_BACKOFF = 2'd1;
  localparam logic [1:0] PH_RECV    = 2'd2;
  localparam logic [1:0] PH_SEND    = 2'd3;

  // Config registers
  logic [7:0] frame_ticks_q, first_bit_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ticks_q <= FRAME_TICKS_RST;
      first_bit_q   <= FIRST_BIT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIRST_BIT) first_bit_q <= pwdata[7:0];
      else frame_ticks_q <= pwdata[7:0];
    end
  end

  assign prdata = {24'd0, (paddr[2] == REG_FIRST_BIT) ? first_bit_q : frame_ticks_q};

  // Transaction state
  logic [1:0] phase_q, phase_d;
  logic [7:0] bo_cnt_q, bo_cnt_d;
  logic [7:0] bo_tgt_q, bo_tgt_d;
  logic [7:0] ftick_q, ftick_d;
  logic [7:0] send_q, send_d;
  logic [7:0] recv_q, recv_d;
  logic       got_q, got_d;
  logic       sent_q, sent_d;

  // Handshake
  logic       in_acc, out_take;
  logic       out_vld_q, skid_vld_q;
  swbft_res_t out_q, skid_q, res;

  assign s_axis_tready = !skid_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_take      = out_vld_q && m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // Payload fields
  logic       mode, line;
  logic [7:0] in_byte, in_boff;
  assign mode    = s_axis_tuser;
  assign in_byte = s_axis_tdata[7:0];
  assign in_boff = s_axis_tdata[15:8];
  assign line    = s_axis_tdata[16];

  // Frame tick seen by this beat: 1 when a frame opens, else saturating +1
  logic [7:0] ftick_nxt, bo_inc;
  logic       in_win;
  logic [2:0] win_pos;
  logic       tx_lvl;

  assign ftick_nxt = (phase_q == PH_BACKOFF) ? 8'd1 :
                     (ftick_q == 8'hFF) ? ftick_q : ftick_q + 8'd1;
  assign bo_inc    = (bo_cnt_q == 8'hFF) ? bo_cnt_q : bo_cnt_q + 8'd1;
  assign in_win    = (ftick_nxt >= first_bit_q) &&
                     ({1'b0, ftick_nxt} <= {1'b0, first_bit_q} + 9'd7);
  assign win_pos   = 3'(ftick_nxt - first_bit_q);

  always_comb begin
    if (in_win) tx_lvl = send_q[3'd7 - win_pos];
    else if (ftick_nxt < first_bit_q) tx_lvl = 1'b0;
    else tx_lvl = send_q[0];
  end

  logic den, dlev, done;

  always_comb begin
    phase_d  = phase_q;
    bo_cnt_d = bo_cnt_q;
    bo_tgt_d = bo_tgt_q;
    ftick_d  = ftick_q;
    send_d   = send_q;
    recv_d   = recv_q;
    got_d    = got_q;
    sent_d   = sent_q;
    den      = 1'b0;
    dlev     = 1'b0;
    done     = 1'b0;
    if (mode == MODE_START) begin
      phase_d  = PH_BACKOFF;
      send_d   = in_byte;
      bo_tgt_d = (in_boff == 8'd0) ? 8'd1 : in_boff;
      bo_cnt_d = 8'd0;
      ftick_d  = 8'd0;
      recv_d   = 8'd0;
      got_d    = 1'b0;
      sent_d   = 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_BACKOFF: begin
          if (!line) begin
            // low line opens a receive frame, backoff paused
            phase_d = PH_RECV;
            ftick_d = ftick_nxt;
            recv_d  = in_win ? {7'd0, line} : 8'd0;
            if (ftick_nxt >= frame_ticks_q) begin
              got_d   = 1'b1;
              phase_d = PH_BACKOFF;
            end
          end else begin
            bo_cnt_d = bo_inc;
            if (bo_inc >= bo_tgt_q) begin
              phase_d = PH_SEND;
              ftick_d = ftick_nxt;
              if (ftick_nxt >= frame_ticks_q) begin
                sent_d  = 1'b1;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                den  = 1'b1;
                dlev = tx_lvl;
              end
            end
          end
        end
        PH_RECV: begin
          ftick_d = ftick_nxt;
          if (in_win) recv_d = {recv_q[6:0], line};
          if (ftick_nxt >= frame_ticks_q) begin
            got_d   = 1'b1;
            phase_d = PH_BACKOFF;
          end
        end
        PH_SEND: begin
          ftick_d = ftick_nxt;
          if (ftick_nxt >= frame_ticks_q) begin
            sent_d  = 1'b1;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            den  = 1'b1;
            dlev = tx_lvl;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.drive_enable  = den;
    res.drive_level   = dlev;
    res.busy_res      = (phase_d != PH_IDLE);
    res.done_res      = done;
    res.received_byte = got_d ? recv_d : 8'd0;
    res.received_any  = got_d;
    res.transmitted   = sent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bo_cnt_q <= 8'd0;
      bo_tgt_q <= 8'd0;
      ftick_q  <= 8'd0;
      send_q   <= 8'd0;
      recv_q   <= 8'd0;
      got_q    <= 1'b0;
      sent_q   <= 1'b0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      bo_cnt_q <= bo_cnt_d;
      bo_tgt_q <= bo_tgt_d;
      ftick_q  <= ftick_d;
      send_q   <= send_d;
      recv_q   <= recv_d;
      got_q    <= got_d;
      sent_q   <= sent_d;
    end
  end

  // Output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_vld_q || out_take) out_vld_q <= 1'b1;
      else skid_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) out_q <= skid_q;
    end else if (in_acc) begin
      if (!out_vld_q || out_take) out_q <= res;
      else skid_q <= res;
    end
  end

`include "assert_macros.svh"

  `SWB_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q, "skid full with output empty")
  `SWB_ASSERT_IMP(a_level_needs_drive, out_vld_q && out_q.drive_level, out_q.drive_enable, "level without drive")
  `SWB_ASSERT_IMP(a_done_not_busy, out_vld_q && out_q.done_res, !out_q.busy_res && out_q.transmitted, "done while busy")
  `SWB_ASSERT_IMP(a_send_not_sent, phase_q == PH_SEND, !sent_q, "sent flag during send frame")
  `SWB_ASSERT_IMP(a_recv_tick_live, phase_q == PH_RECV, ftick_q != 8'd0, "receive frame at tick zero")

endmodule
